FILE: src/pst_pkg.sv
// Shared types and constants for the process slot table.
`default_nettype none

package pst_pkg;

    // Command opcodes as they arrive on the input stream.
    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_KILL    = 3'd1;
    localparam logic [2:0] OP_SUSPEND = 3'd2;
    localparam logic [2:0] OP_RESUME  = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;
    localparam logic [2:0] OP_LIST    = 3'd5;

    // Slot states.
    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_SUSP = 2'd2;

    // Most results a single list command may produce.
    localparam logic [6:0] MAX_LIST = 7'd64;

    // Stream widths.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // Command kind after classification in the front end.
    typedef enum logic [2:0] {
        K_CREATE,
        K_KILL,
        K_SUSPEND,
        K_RESUME,
        K_QUERY,
        K_LIST,
        K_FAIL
    } kind_t;

    // One classified command in the queue between front and back.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] target_id;
        logic [7:0]  platform;
        logic [6:0]  limit;
    } cmd_t;

    // One table entry as stored in the slot memory.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] id;
        logic [7:0]  platform;
    } entry_t;

    // One result transaction.
    typedef struct packed {
        logic        ok;
        logic [5:0]  slot_index;
        logic [31:0] entry_id;
        logic [1:0]  entry_state;
        logic [7:0]  entry_platform;
        logic [6:0]  live_total;
        logic        last;
    } result_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN,
        BK_FLUSH
    } bk_state_t;

endpackage

`default_nettype wire

FILE: src/pst_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
`default_nettype none

module pst_front (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // opcode[2:0], target_id[34:3], platform_code[42:35], list_limit[49:43]
    input  wire  [pst_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  wire                                  accept_en,
    output logic                                 q_valid,
    output pst_pkg::cmd_t                        q_cmd,
    input  wire                                  q_pop
);
    import pst_pkg::*;

    logic [2:0]  in_opcode;
    logic [31:0] in_target;
    logic [7:0]  in_platform;
    logic [6:0]  in_limit;
    cmd_t        cls_cmd;
    logic        push;

    cmd_t        q_mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    // Unpack the input transaction.
    assign in_opcode   = s_tdata[2:0];
    assign in_target   = s_tdata[34:3];
    assign in_platform = s_tdata[42:35];
    assign in_limit    = s_tdata[49:43];

    // Classify: unknown opcodes and empty lists become immediate failures.
    always_comb begin
        cls_cmd.target_id = in_target;
        cls_cmd.platform  = in_platform;
        cls_cmd.limit     = (in_limit > MAX_LIST) ? MAX_LIST : in_limit;
        unique case (in_opcode)
            OP_CREATE:  cls_cmd.kind = K_CREATE;
            OP_KILL:    cls_cmd.kind = K_KILL;
            OP_SUSPEND: cls_cmd.kind = K_SUSPEND;
            OP_RESUME:  cls_cmd.kind = K_RESUME;
            OP_QUERY:   cls_cmd.kind = K_QUERY;
            OP_LIST:    cls_cmd.kind = (in_limit == 7'd0) ? K_FAIL : K_LIST;
            default:    cls_cmd.kind = K_FAIL;
        endcase
    end

    // Two-entry queue.
    assign s_tready = (count_reg != 2'd2) && accept_en;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (!push && q_pop) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/pst_back.sv
// Back end: slot memory, scanning sequencer and result register.
`default_nettype none

module pst_back #(
    parameter int TABLE_SLOTS = 64
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              q_valid,
    input  wire pst_pkg::cmd_t q_cmd,
    output logic             q_pop,
    output logic             accept_en,
    output logic             m_valid,
    input  wire              m_ready,
    output pst_pkg::result_t m_result
);
    import pst_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int LW = $clog2(TABLE_SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

    // Slot memory with registered read.
    entry_t          mem [TABLE_SLOTS];
    entry_t          rd_q_reg;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    entry_t          wr_data;

    bk_state_t       state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            hold_valid_reg, hold_valid_next;
    logic [IW-1:0]   hold_idx_reg, hold_idx_next;
    entry_t          hold_ent_reg, hold_ent_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic [LW-1:0]   live_reg, live_next;
    logic [31:0]     nid_reg, nid_next;
    logic            m_valid_reg;
    result_t         out_reg;

    logic            out_free;
    logic            emit;
    result_t         emit_res;
    result_t         fail_res;
    logic            last_slot;
    logic            match;
    logic            state_ok;
    logic [1:0]      new_state;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign accept_en = (state_reg != BK_CLEAR);
    assign last_slot = (idx_reg == LAST_IDX);
    assign match     = (rd_q_reg.status != ST_FREE) && (rd_q_reg.id == cmd_reg.target_id);

    // Failure result carries only the live count and the last flag.
    always_comb begin
        fail_res            = '0;
        fail_res.live_total = 7'(live_reg);
        fail_res.last       = 1'b1;
    end

    // Whether a found entry is in the state the command needs, and its new state.
    always_comb begin
        state_ok  = 1'b1;
        new_state = rd_q_reg.status;
        unique case (cmd_reg.kind)
            K_KILL: begin
                new_state = ST_FREE;
            end
            K_SUSPEND: begin
                state_ok  = (rd_q_reg.status == ST_RUN);
                new_state = ST_SUSP;
            end
            K_RESUME: begin
                state_ok  = (rd_q_reg.status == ST_SUSP);
                new_state = ST_RUN;
            end
            default: begin
                new_state = rd_q_reg.status;
            end
        endcase
    end

    // Sequencer: clearing pass, command dispatch, slot scan and list flush.
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        hold_ent_next   = hold_ent_reg;
        cnt_next        = cnt_reg;
        live_next       = live_reg;
        nid_next        = nid_reg;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = '0;
        q_pop           = 1'b0;
        emit            = 1'b0;
        emit_res        = fail_res;

        unique case (state_reg)
            BK_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (last_slot) begin
                    idx_next   = '0;
                    state_next = BK_IDLE;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            BK_IDLE: begin
                if (q_valid) begin
                    if (q_cmd.kind == K_FAIL) begin
                        if (out_free) begin
                            q_pop = 1'b1;
                            emit  = 1'b1;
                        end
                    end else begin
                        q_pop           = 1'b1;
                        cmd_next        = q_cmd;
                        rd_addr         = '0;
                        idx_next        = '0;
                        hold_valid_next = 1'b0;
                        cnt_next        = 7'd0;
                        state_next      = BK_SCAN;
                    end
                end
            end

            BK_SCAN: begin
                unique case (cmd_reg.kind)
                    K_CREATE: begin
                        if (rd_q_reg.status == ST_FREE) begin
                            if (out_free) begin
                                wr_en                   = 1'b1;
                                wr_data.status          = ST_RUN;
                                wr_data.id              = nid_reg;
                                wr_data.platform        = cmd_reg.platform;
                                nid_next                = nid_reg + 32'd1;
                                live_next               = live_reg + LW'(1);
                                emit                    = 1'b1;
                                emit_res.ok             = 1'b1;
                                emit_res.slot_index     = 6'(idx_reg);
                                emit_res.entry_id       = nid_reg;
                                emit_res.entry_state    = ST_RUN;
                                emit_res.entry_platform = cmd_reg.platform;
                                emit_res.live_total     = 7'(live_reg + LW'(1));
                                state_next              = BK_IDLE;
                            end
                        end else if (last_slot) begin
                            if (out_free) begin
                                emit       = 1'b1;
                                state_next = BK_IDLE;
                            end
                        end else begin
                            rd_addr  = idx_reg + IW'(1);
                            idx_next = idx_reg + IW'(1);
                        end
                    end

                    K_KILL, K_SUSPEND, K_RESUME, K_QUERY: begin
                        if (match || last_slot) begin
                            if (out_free) begin
                                emit       = 1'b1;
                                state_next = BK_IDLE;
                                if (match && state_ok) begin
                                    if (cmd_reg.kind != K_QUERY) begin
                                        wr_en            = 1'b1;
                                        wr_data.status   = new_state;
                                        wr_data.id       = rd_q_reg.id;
                                        wr_data.platform = rd_q_reg.platform;
                                    end
                                    if (cmd_reg.kind == K_KILL) begin
                                        live_next = live_reg - LW'(1);
                                    end
                                    emit_res.ok             = 1'b1;
                                    emit_res.slot_index     = 6'(idx_reg);
                                    emit_res.entry_id       = rd_q_reg.id;
                                    emit_res.entry_state    = new_state;
                                    emit_res.entry_platform = rd_q_reg.platform;
                                    emit_res.live_total     = (cmd_reg.kind == K_KILL) ?
                                        7'(live_reg - LW'(1)) : 7'(live_reg);
                                end
                            end
                        end else begin
                            rd_addr  = idx_reg + IW'(1);
                            idx_next = idx_reg + IW'(1);
                        end
                    end

                    K_LIST: begin
                        // A found entry is held back until the next one is found so the final one can carry last.
                        if (rd_q_reg.status == ST_RUN) begin
                            if (!hold_valid_reg || out_free) begin
                                if (hold_valid_reg) begin
                                    emit                    = 1'b1;
                                    emit_res.ok             = 1'b1;
                                    emit_res.slot_index     = 6'(hold_idx_reg);
                                    emit_res.entry_id       = hold_ent_reg.id;
                                    emit_res.entry_state    = hold_ent_reg.status;
                                    emit_res.entry_platform = hold_ent_reg.platform;
                                    emit_res.last           = 1'b0;
                                end
                                hold_valid_next = 1'b1;
                                hold_idx_next   = idx_reg;
                                hold_ent_next   = rd_q_reg;
                                cnt_next        = cnt_reg + 7'd1;
                                if ((cnt_reg + 7'd1 == cmd_reg.limit) || last_slot) begin
                                    state_next = BK_FLUSH;
                                end else begin
                                    rd_addr  = idx_reg + IW'(1);
                                    idx_next = idx_reg + IW'(1);
                                end
                            end
                        end else if (last_slot) begin
                            state_next = BK_FLUSH;
                        end else begin
                            rd_addr  = idx_reg + IW'(1);
                            idx_next = idx_reg + IW'(1);
                        end
                    end

                    default: begin
                        state_next = BK_IDLE;
                    end
                endcase
            end

            BK_FLUSH: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = BK_IDLE;
                    if (hold_valid_reg) begin
                        emit_res.ok             = 1'b1;
                        emit_res.slot_index     = 6'(hold_idx_reg);
                        emit_res.entry_id       = hold_ent_reg.id;
                        emit_res.entry_state    = hold_ent_reg.status;
                        emit_res.entry_platform = hold_ent_reg.platform;
                    end
                end
            end

            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_CLEAR;
            idx_reg        <= '0;
            hold_valid_reg <= 1'b0;
            cnt_reg        <= 7'd0;
            live_reg       <= '0;
            nid_reg        <= 32'd1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            hold_valid_reg <= hold_valid_next;
            cnt_reg        <= cnt_next;
            live_reg       <= live_next;
            nid_reg        <= nid_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        hold_idx_reg <= hold_idx_next;
        hold_ent_reg <= hold_ent_next;
        if (emit) begin
            out_reg <= emit_res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;

`ifndef SYNTH
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= LW'(TABLE_SLOTS))
        else $error("Live count exceeds the table size.");

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_CLEAR) |-> !m_valid_reg)
        else $error("Result presented during the clearing pass.");

    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_reg.ok) |->
            (out_reg.slot_index == 6'd0 && out_reg.entry_id == 32'd0 && out_reg.last))
        else $error("Failure result carries entry fields.");

    a_pop_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("Queue popped while empty.");

    a_list_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SCAN && cmd_reg.kind == K_LIST) |-> (cnt_reg < cmd_reg.limit))
        else $error("List scan continued past its limit.");
`endif

endmodule

`default_nettype wire

FILE: src/process_slot_table.sv
// Process slot table: command front end, queue and table back end.
//
// A table of TABLE_SLOTS process slots driven by one command per input
// transaction (create, kill, suspend, resume, query, list). The back end
// keeps the slots in a memory with a read and a write port and walks it
// one slot per clock, holding while a result waits for the output
// register: a command is dispatched from the idle state and then scans the
// slots up to the one it acts on; unknown opcodes and a list with limit
// zero are answered from the idle state without a scan. A two-entry queue
// lets new commands be accepted while a command is scanning or a result
// waits on m_tready. After reset the table is cleared one slot per cycle,
// during which s_tready stays low.
`default_nettype none

module process_slot_table #(
    parameter int TABLE_SLOTS = 64
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // opcode[2:0], target_id[34:3], platform_code[42:35], list_limit[49:43]
    input  wire  [pst_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // ok[0], slot_index[6:1], entry_id[38:7], entry_state[40:39],
    // entry_platform[48:41], live_total[55:49]
    output logic [pst_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);
    import pst_pkg::*;

    logic    q_valid;
    cmd_t    q_cmd;
    logic    q_pop;
    logic    accept_en;
    result_t result;

    pst_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .accept_en (accept_en),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    pst_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .accept_en (accept_en),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (result)
    );

    // Pack the result transaction.
    assign m_tdata = {result.live_total, result.entry_platform, result.entry_state,
                      result.entry_id, result.slot_index, result.ok};
    assign m_tlast = result.last;

endmodule

`default_nettype wire
